FILE: rtl/assert_macros.svh
// assertion macros used by ping_rtt_statistics
// clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/prtt_pkg.sv
// types and constants for the round trip statistics block
// no dependencies
`default_nettype none

package prtt_pkg;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_REPLY   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  // smoothing weights: srtt gets 1/8 of each sample, mdev 1/4
  localparam int unsigned AVG_SHIFT = 3;
  localparam int unsigned AVG_ROUND = 4;
  localparam int unsigned DEV_SHIFT = 2;
  localparam int unsigned DEV_ROUND = 2;

  // x*100 is formed as (x<<6) + (x<<5) + (x<<2)
  localparam int unsigned PCT_SH_A = 6;
  localparam int unsigned PCT_SH_B = 5;
  localparam int unsigned PCT_SH_C = 2;
  localparam int unsigned PCT_BITS = 8;
  localparam logic [7:0]  PCT_SAT  = 8'hFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] reply_id;
    logic [31:0] now_ms;
    logic [31:0] stamp_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sent_total;
    logic [31:0] received_total;
    logic [7:0]  percent_received;
    logic        none_sent;
    logic [31:0] round_trip;
    logic [31:0] smoothed_round_trip;
    logic [31:0] mean_deviation;
    logic [31:0] largest_round_trip;
    logic [31:0] smallest_round_trip;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/ping_rtt_statistics.sv
// round trip statistics: counters, smoothed rtt, mean deviation, extremes, percent received
// one shared add/subtract unit under a sequencer; uses prtt_pkg and assert_macros.svh
//
// usage:
//   input channel in_valid_i / in_stall_o carries one command per transfer.
//   request, restart, unused codes and replies with a foreign id leave the sequencer idle
//   and give no result. a reply whose id equals the echo_id register starts the
//   sequencer and in_stall_o stays high until its result is in the output register.
//   a matching reply that seeds the estimates (first reply after restart or counter
//   wrap) skips the smoothing and compare steps, one before any request is counted
//   skips the percentage steps, and a saturating percentage skips the division; the
//   add/subtract unit does one step per cycle: the difference, the two three-step
//   smoothing updates, the two compares, the three steps of received*100+sent/2,
//   one saturation check and eight restoring division steps for the percentage.
//   results leave on out_valid_o / out_stall_i from an output register; the next
//   item is taken while a result waits, and its own result waits in the last
//   sequencer step while the receiver stalls.
//   cfg_we_i writes cfg_wdata_i into echo_id at once; write only while idle.
//   reset clears the counters, the estimates, echo_id and the output register.
`default_nettype none

`include "assert_macros.svh"

module ping_rtt_statistics #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire prtt_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output prtt_pkg::out_item_t     out_data_o
);

  import prtt_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned UW = (TW + 4 > CW + 9) ? TW + 4 : CW + 9;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EST,
    S_ERRN,
    S_AVG7,
    S_AVGR,
    S_AVGK,
    S_DEV3,
    S_DEVE,
    S_DEVK,
    S_MAX,
    S_MIN,
    S_MUL1,
    S_MUL2,
    S_HALF,
    S_SAT,
    S_DIV,
    S_OUT
  } state_e;

  state_e        state_q, state_d;
  logic [15:0]   echo_id_q, echo_id_d;
  logic [CW-1:0] snt_q, snt_d, rcv_q, rcv_d;
  logic [TW-1:0] srtt_q, srtt_d, mdev_q, mdev_d, max_q, max_d, min_q, min_d;
  logic [TW-1:0] rtt_q, rtt_d, err_q, err_d;
  logic [UW-1:0] acc_q, acc_d, div_q, div_d;
  logic [7:0]    pct_q, pct_d;
  logic [2:0]    cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  // shared add/subtract unit
  logic [UW-1:0] op_a, op_b, sum;
  logic          op_sub, carry;
  logic [UW:0]   add_res;

  assign add_res = {1'b0, op_a} + {1'b0, op_b ^ {UW{op_sub}}} + (UW + 1)'(op_sub);
  assign sum     = add_res[UW-1:0];
  assign carry   = add_res[UW];

  logic   in_xfer, out_xfer, seed, out_free, reply_hit;
  state_e pct_start;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign seed        = (rcv_q == CW'(1));
  assign pct_start   = (snt_q == '0) ? S_OUT : S_MUL1;
  assign reply_hit   = in_xfer && (in_data_i.cmd == CMD_REPLY) &&
                       (in_data_i.reply_id == echo_id_q);

  always_comb begin
    state_d     = state_q;
    echo_id_d   = echo_id_q;
    snt_d       = snt_q;
    rcv_d       = rcv_q;
    srtt_d      = srtt_q;
    mdev_d      = mdev_q;
    max_d       = max_q;
    min_d       = min_q;
    rtt_d       = rtt_q;
    err_d       = err_q;
    acc_d       = acc_q;
    div_d       = div_q;
    pct_d       = pct_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_xfer;
    out_d       = out_q;
    op_a        = acc_q;
    op_b        = '0;
    op_sub      = 1'b0;

    if (cfg_we_i) begin
      echo_id_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        // rtt difference is formed while waiting so a reply can start at once
        op_a   = UW'(TW'(in_data_i.now_ms));
        op_b   = UW'(TW'(in_data_i.stamp_ms));
        op_sub = 1'b1;
        if (in_xfer) begin
          case (in_data_i.cmd)
            CMD_REQUEST: begin
              snt_d = snt_q + CW'(1);
            end
            CMD_RESTART: begin
              snt_d = '0;
              rcv_d = '0;
            end
            CMD_REPLY: begin
              if (in_data_i.reply_id == echo_id_q) begin
                rcv_d   = rcv_q + CW'(1);
                rtt_d   = TW'(sum);
                state_d = S_EST;
              end
            end
            default: ;
          endcase
        end
      end
      S_EST: begin
        op_a   = UW'(rtt_q);
        op_b   = UW'(srtt_q);
        op_sub = 1'b1;
        if (seed) begin
          srtt_d  = rtt_q;
          mdev_d  = '0;
          max_d   = rtt_q;
          min_d   = rtt_q;
          state_d = pct_start;
        end else if (carry) begin
          err_d   = TW'(sum);
          state_d = S_AVG7;
        end else begin
          state_d = S_ERRN;
        end
      end
      S_ERRN: begin
        op_a    = UW'(srtt_q);
        op_b    = UW'(rtt_q);
        op_sub  = 1'b1;
        err_d   = TW'(sum);
        state_d = S_AVG7;
      end
      S_AVG7: begin
        op_a    = UW'(srtt_q) << AVG_SHIFT;
        op_b    = UW'(srtt_q);
        op_sub  = 1'b1;
        acc_d   = sum;
        state_d = S_AVGR;
      end
      S_AVGR: begin
        op_b    = UW'(rtt_q);
        acc_d   = sum;
        state_d = S_AVGK;
      end
      S_AVGK: begin
        op_b    = UW'(AVG_ROUND);
        srtt_d  = TW'(sum >> AVG_SHIFT);
        state_d = S_DEV3;
      end
      S_DEV3: begin
        op_a    = UW'(mdev_q) << DEV_SHIFT;
        op_b    = UW'(mdev_q);
        op_sub  = 1'b1;
        acc_d   = sum;
        state_d = S_DEVE;
      end
      S_DEVE: begin
        op_b    = UW'(err_q);
        acc_d   = sum;
        state_d = S_DEVK;
      end
      S_DEVK: begin
        op_b    = UW'(DEV_ROUND);
        mdev_d  = TW'(sum >> DEV_SHIFT);
        state_d = S_MAX;
      end
      S_MAX: begin
        op_a   = UW'(rtt_q);
        op_b   = UW'(max_q);
        op_sub = 1'b1;
        if (carry) begin
          max_d = rtt_q;
        end
        state_d = S_MIN;
      end
      S_MIN: begin
        op_a   = UW'(rtt_q);
        op_b   = UW'(min_q);
        op_sub = 1'b1;
        if (!carry) begin
          min_d = rtt_q;
        end
        state_d = pct_start;
      end
      S_MUL1: begin
        op_a    = UW'(rcv_q) << PCT_SH_A;
        op_b    = UW'(rcv_q) << PCT_SH_B;
        acc_d   = sum;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        op_b    = UW'(rcv_q) << PCT_SH_C;
        acc_d   = sum;
        state_d = S_HALF;
      end
      S_HALF: begin
        op_b    = UW'(snt_q >> 1);
        acc_d   = sum;
        state_d = S_SAT;
      end
      S_SAT: begin
        // quotient of 256 or more saturates
        op_b   = UW'(snt_q) << PCT_BITS;
        op_sub = 1'b1;
        if (carry) begin
          pct_d   = PCT_SAT;
          state_d = S_OUT;
        end else begin
          div_d   = UW'(snt_q) << (PCT_BITS - 1);
          cnt_d   = 3'(PCT_BITS - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        op_b   = div_q;
        op_sub = 1'b1;
        if (carry) begin
          acc_d = sum;
        end
        pct_d = {pct_q[6:0], carry};
        div_d = div_q >> 1;
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d                  = 1'b1;
          out_d.sent_total             = 32'(snt_q);
          out_d.received_total         = 32'(rcv_q);
          out_d.none_sent              = (snt_q == '0);
          out_d.percent_received       = (snt_q == '0) ? 8'd0 : pct_q;
          out_d.round_trip             = 32'(rtt_q);
          out_d.smoothed_round_trip    = 32'(srtt_q);
          out_d.mean_deviation         = 32'(mdev_q);
          out_d.largest_round_trip     = 32'(max_q);
          out_d.smallest_round_trip    = 32'(min_q);
          state_d                      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      echo_id_q   <= '0;
      snt_q       <= '0;
      rcv_q       <= '0;
      srtt_q      <= '0;
      mdev_q      <= '0;
      max_q       <= '0;
      min_q       <= '0;
      rtt_q       <= '0;
      err_q       <= '0;
      acc_q       <= '0;
      div_q       <= '0;
      pct_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      echo_id_q   <= echo_id_d;
      snt_q       <= snt_d;
      rcv_q       <= rcv_d;
      srtt_q      <= srtt_d;
      mdev_q      <= mdev_d;
      max_q       <= max_d;
      min_q       <= min_d;
      rtt_q       <= rtt_d;
      err_q       <= err_d;
      acc_q       <= acc_d;
      div_q       <= div_d;
      pct_q       <= pct_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  `ASSERT_NEXT(a_reply_starts, reply_hit, state_q == S_EST)
  `ASSERT_IMPLY(a_min_le_max, 1'b1, min_q <= max_q)
  `ASSERT_IMPLY(a_result_from_out, $rose(out_valid_q), $past(state_q) == S_OUT)
  `ASSERT_IMPLY(a_div_rem_bound, state_q == S_DIV, acc_q < (div_q << 1))

endmodule

`default_nettype wire
